// File: hdl/df1rx_pkg.sv
// Shared types and constants for the DF1 response frame receiver.
// No dependencies; imported by every other module of the block.
`timescale 1ns / 1ps

package df1rx_pkg;

    // Framing characters
    localparam logic [7:0] DLE = 8'h10;
    localparam logic [7:0] STX = 8'h02;
    localparam logic [7:0] ETX = 8'h03;

    // Frame geometry: header + trailer overhead and unstuffed body length
    localparam int unsigned MIN_FRAME_LEN = 13;
    localparam int unsigned FRAME_OVERHEAD = 5;
    localparam logic [7:0] MIN_RAW_BODY = 8'(MIN_FRAME_LEN - FRAME_OVERHEAD);
    localparam logic [7:0] BODY_LEN = 8'd8;
    localparam logic [7:0] CNT_MAX = 8'hFF;

    // Configuration register indexes and reset values
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_EXP_CMD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXP_TRN = 1'b1;
    localparam logic [7:0] RST_EXP_CMD = 8'h4F;
    localparam logic [15:0] RST_EXP_TRN = 16'h0000;

    // Event queue between front and back
    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Receive state of the byte classifier
    typedef enum logic [2:0] {
        ST_HUNT,
        ST_HUNT_DLE,
        ST_BODY,
        ST_BODY_DLE,
        ST_BCC
    } t_rx_state;

    // Events passed from front to back
    typedef enum logic [1:0] {
        EV_START,   // DLE STX seen: clear frame state
        EV_RAW,     // escape DLE: counts as a raw byte only
        EV_BODY,    // unstuffed body byte
        EV_CHECK    // BCC byte: finish the frame
    } t_evt_kind;

    typedef struct packed {
        t_evt_kind  kind;
        logic [7:0] data;
    } t_evt;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Frame result codes
    typedef enum logic [2:0] {
        FS_OK        = 3'd0,
        FS_SHORT     = 3'd1,
        FS_BCC_ERR   = 3'd2,
        FS_BAD_LEN   = 3'd3,
        FS_CMD_ERR   = 3'd4,
        FS_TRN_ERR   = 3'd5
    } t_frame_status;

endpackage

// File: hdl/df1rx_front.sv
// Byte classifier: hunts DLE STX, strips DLE stuffing, emits frame events.
// Depends on df1rx_pkg.
`timescale 1ns / 1ps

module df1rx_front
    import df1rx_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_rx_byte,
    output logic       o_stall,
    input  t_q_stat    i_q_stat,
    output logic       o_push,
    output t_evt       o_evt
);

    t_rx_state r_state, n_state;
    logic      accept;

    assign o_stall = i_q_stat.full;
    assign accept  = i_valid & ~i_q_stat.full;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HUNT;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    // Next state and event generation
    always_comb begin
        n_state       = r_state;
        o_push        = 1'b0;
        o_evt.kind    = EV_BODY;
        o_evt.data    = i_rx_byte;
        case (r_state)
            ST_HUNT: begin
                if (i_rx_byte == DLE) n_state = ST_HUNT_DLE;
            end
            ST_HUNT_DLE: begin
                if (i_rx_byte == STX) begin
                    n_state    = ST_BODY;
                    o_push     = accept;
                    o_evt.kind = EV_START;
                end else if (i_rx_byte != DLE) begin
                    n_state = ST_HUNT;
                end
            end
            ST_BODY: begin
                o_push = accept;
                if (i_rx_byte == DLE) begin
                    n_state    = ST_BODY_DLE;
                    o_evt.kind = EV_RAW;
                end
            end
            ST_BODY_DLE: begin
                if (i_rx_byte == DLE) begin
                    // stuffed data byte 0x10
                    n_state = ST_BODY;
                    o_push  = accept;
                end else if (i_rx_byte == ETX) begin
                    n_state = ST_BCC;
                end else if (i_rx_byte == STX) begin
                    // restart: drop the frame in progress
                    n_state    = ST_BODY;
                    o_push     = accept;
                    o_evt.kind = EV_START;
                end else begin
                    n_state = ST_HUNT;
                end
            end
            ST_BCC: begin
                n_state    = ST_HUNT;
                o_push     = accept;
                o_evt.kind = EV_CHECK;
            end
            default: begin
                n_state = ST_HUNT;
            end
        endcase
    end

endmodule

// File: hdl/df1rx_queue.sv
// Short event queue that decouples the classifier from the frame checker.
// Depends on df1rx_pkg.
`timescale 1ns / 1ps

module df1rx_queue
    import df1rx_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_evt    i_evt,
    input  logic    i_pop,
    output t_evt    o_evt,
    output t_q_stat o_stat
);

    t_evt               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic               do_push;
    logic               do_pop;

    assign o_stat.full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push & ~o_stat.full;
    assign do_pop       = i_pop & ~o_stat.empty;
    assign o_evt        = r_mem[r_rd_ptr];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_evt;
        end
    end

endmodule

// File: hdl/df1rx_back.sv
// Frame checker: counts, sums and captures body bytes, then grades the frame
// and holds the result in an output register. Depends on df1rx_pkg.
`timescale 1ns / 1ps

module df1rx_back
    import df1rx_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_q_stat               i_q_stat,
    input  t_evt                  i_evt,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [2:0]            o_frame_status,
    output logic [7:0]            o_dest_node,
    output logic [7:0]            o_source_node,
    output logic [7:0]            o_reply_status,
    output logic [15:0]           o_transaction_seen,
    output logic [15:0]           o_data_word
);

    logic [7:0]    r_exp_cmd;
    logic [15:0]   r_exp_trn;
    logic [7:0]    r_raw_cnt;
    logic [7:0]    r_body_cnt;
    logic [7:0]    r_sum;
    logic [7:0]    r_dest;
    logic [7:0]    r_src;
    logic [7:0]    r_cmd;
    logic [7:0]    r_sts;
    logic [15:0]   r_trn;
    logic [15:0]   r_data;
    logic          r_out_valid;
    logic [2:0]    r_out_status;
    logic [7:0]    r_out_dest;
    logic [7:0]    r_out_src;
    logic [7:0]    r_out_sts;
    logic [15:0]   r_out_trn;
    logic [15:0]   r_out_data;
    logic          out_free;
    logic          is_check;
    logic          take_body;
    t_frame_status status;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_cmd <= RST_EXP_CMD;
            r_exp_trn <= RST_EXP_TRN;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_EXP_CMD: r_exp_cmd <= i_cfg_data[7:0];
                CFG_EXP_TRN: r_exp_trn <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Pop when the head event can be carried out
    assign out_free  = ~r_out_valid | ~i_stall;
    assign is_check  = (i_evt.kind == EV_CHECK);
    assign o_pop     = ~i_q_stat.empty & (~is_check | out_free);
    assign take_body = o_pop & (i_evt.kind == EV_BODY);

    // Frame grading, first failing check wins
    always_comb begin
        if (r_raw_cnt < MIN_RAW_BODY) begin
            status = FS_SHORT;
        end else if (8'(r_sum + i_evt.data) != 8'd0) begin
            status = FS_BCC_ERR;
        end else if (r_body_cnt != BODY_LEN) begin
            status = FS_BAD_LEN;
        end else if (r_cmd != r_exp_cmd) begin
            status = FS_CMD_ERR;
        end else if (r_trn != r_exp_trn) begin
            status = FS_TRN_ERR;
        end else begin
            status = FS_OK;
        end
    end

    // Frame accumulation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_cnt  <= '0;
            r_body_cnt <= '0;
            r_sum      <= '0;
            r_dest     <= '0;
            r_src      <= '0;
            r_cmd      <= '0;
            r_sts      <= '0;
            r_trn      <= '0;
            r_data     <= '0;
        end else if (o_pop) begin
            case (i_evt.kind)
                EV_START: begin
                    r_raw_cnt  <= '0;
                    r_body_cnt <= '0;
                    r_sum      <= '0;
                    r_dest     <= '0;
                    r_src      <= '0;
                    r_cmd      <= '0;
                    r_sts      <= '0;
                    r_trn      <= '0;
                    r_data     <= '0;
                end
                EV_RAW, EV_BODY: begin
                    if (r_raw_cnt != CNT_MAX) r_raw_cnt <= r_raw_cnt + 8'd1;
                end
                default: ;
            endcase
            if (take_body) begin
                r_sum <= r_sum + i_evt.data;
                if (r_body_cnt != CNT_MAX) r_body_cnt <= r_body_cnt + 8'd1;
                if (r_body_cnt < BODY_LEN) begin
                    case (r_body_cnt[2:0])
                        3'd0: r_dest        <= i_evt.data;
                        3'd1: r_src         <= i_evt.data;
                        3'd2: r_cmd         <= i_evt.data;
                        3'd3: r_sts         <= i_evt.data;
                        3'd4: r_trn[7:0]    <= i_evt.data;
                        3'd5: r_trn[15:8]   <= i_evt.data;
                        3'd6: r_data[7:0]   <= i_evt.data;
                        3'd7: r_data[15:8]  <= i_evt.data;
                        default: ;
                    endcase
                end
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && is_check) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && is_check) begin
            r_out_status <= status;
            r_out_dest   <= r_dest;
            r_out_src    <= r_src;
            r_out_sts    <= r_sts;
            r_out_trn    <= r_trn;
            r_out_data   <= r_data;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_frame_status     = r_out_status;
    assign o_dest_node        = r_out_dest;
    assign o_source_node      = r_out_src;
    assign o_reply_status     = r_out_sts;
    assign o_transaction_seen = r_out_trn;
    assign o_data_word        = r_out_data;

endmodule

// File: hdl/df1_response_frame_receiver.sv
// Channel  Handshake                 Payload
// in       i_valid / o_stall         i_rx_byte
// out      o_valid / i_stall         o_frame_status, o_dest_node, o_source_node,
//                                    o_reply_status, o_transaction_seen, o_data_word
// cfg      i_cfg_we                  i_cfg_idx, i_cfg_data
//
// One byte is taken per cycle while o_stall is low; the checker carries out one
// queued event per cycle unless a check event waits on a stalled output. Each
// result passes the event queue and the output register. Synchronous active-low
// reset clears all control state and loads the configuration defaults. A stalled
// output holds the result; the two-entry event queue fills and the input stalls.
//
// Top level of the DF1 response frame receiver.
// Depends on df1rx_pkg, df1rx_front, df1rx_queue and df1rx_back.
`timescale 1ns / 1ps

module df1_response_frame_receiver
    import df1rx_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [7:0]            i_rx_byte,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [2:0]            o_frame_status,
    output logic [7:0]            o_dest_node,
    output logic [7:0]            o_source_node,
    output logic [7:0]            o_reply_status,
    output logic [15:0]           o_transaction_seen,
    output logic [15:0]           o_data_word
);

    t_q_stat q_stat;
    t_evt    push_evt;
    t_evt    head_evt;
    logic    push;
    logic    pop;

    df1rx_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_rx_byte (i_rx_byte),
        .o_stall   (o_stall),
        .i_q_stat  (q_stat),
        .o_push    (push),
        .o_evt     (push_evt)
    );

    df1rx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_evt   (push_evt),
        .i_pop   (pop),
        .o_evt   (head_evt),
        .o_stat  (q_stat)
    );

    df1rx_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_q_stat           (q_stat),
        .i_evt              (head_evt),
        .o_pop              (pop),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_frame_status     (o_frame_status),
        .o_dest_node        (o_dest_node),
        .o_source_node      (o_source_node),
        .o_reply_status     (o_reply_status),
        .o_transaction_seen (o_transaction_seen),
        .o_data_word        (o_data_word)
    );

endmodule
